[rtl/imu_pkg.sv]
// Shared types, constants and helpers for the IMU triad error model.
// Used by imu_lane, imu_triad_error_model_top and the port checker.
package imu_pkg;

   localparam int AXES      = 3;
   localparam int NUM_REGS  = 8;
   localparam int FRAC_BITS = 24;
   localparam int DIST_BITS = 24;
   localparam int MUL_W     = 33;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int NUM_W     = 48;
   localparam int CNT_W     = 6;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      REG_QUANTUM,
      REG_BIAS_DECAY,
      REG_DRIVE_SIGMA,
      REG_WHITE_SIGMA,
      REG_SCALE_DIAG,
      REG_MISALIGN_FIRST,
      REG_MISALIGN_SECOND,
      REG_TURNON_BIAS
   } reg_idx_type;

   // Sequencer state of one axis lane.
   typedef enum logic [2:0] {
      LN_IDLE,
      LN_MUL,
      LN_DIV,
      LN_FIN,
      LN_DONE
   } lane_state_type;

   typedef struct packed {
      logic signed [31:0] truth_x;
      logic signed [31:0] truth_y;
      logic signed [31:0] truth_z;
      logic        [31:0] interval;
      logic signed [15:0] gm_drive_x;
      logic signed [15:0] gm_drive_y;
      logic signed [15:0] gm_drive_z;
      logic signed [15:0] noise_draw_x;
      logic signed [15:0] noise_draw_y;
      logic signed [15:0] noise_draw_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] meas_x;
      logic signed [31:0] meas_y;
      logic signed [31:0] meas_z;
   } rsp_type;

   // Settings one lane needs: the shared model settings, its row of the distortion matrix and its turn-on bias.
   typedef struct packed {
      logic [30:0]      quantum;
      logic [15:0]      bias_decay;
      logic [30:0]      drive_sigma;
      logic [30:0]      white_sigma;
      logic [2:0][15:0] m_row;
      logic [20:0]      turnon;
   } lane_cfg_type;

   // Item fields one lane needs.
   typedef struct packed {
      logic [2:0][31:0] truth;
      logic [31:0]      truth_self;
      logic [31:0]      interval;
      logic [15:0]      gm_drive;
      logic [15:0]      noise_draw;
   } lane_item_type;

   // Handshake between the top level and a lane.
   typedef struct packed {
      logic start;
      logic ack;
   } lane_ctl_type;

   // Saturate a wide signed value to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [NUM_W-1:0] v);
      logic signed [NUM_W-1:0] hi;
      logic signed [NUM_W-1:0] lo;
      hi = NUM_W'(32'sh7FFFFFFF);
      lo = -NUM_W'(33'sh080000000);
      if (v > hi) begin
         sat32 = 32'sh7FFFFFFF;
      end else if (v < lo) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

endpackage

[rtl/imu_lane.sv]
// One axis lane: Gauss-Markov bias, distortion, noise and carry quantizer.
// Depends on imu_pkg; one shared multiplier and a bit-serial remainder unit.
module imu_lane
   import imu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  lane_ctl_type       ctl,
   input  lane_cfg_type       cfg,
   input  lane_item_type      item,
   output logic               done,
   output logic signed [31:0] meas
);

   lane_state_type state_ff, state_in;
   logic [3:0]  st_ff, st_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] gacc_ff, gacc_in;
   logic signed [PROD_W-1:0] uacc_ff, uacc_in;
   logic signed [31:0] gm_bias_ff, gm_bias_in;
   logic signed [31:0] carry_ff, carry_in;
   logic signed [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0] mag_ff, mag_in;
   logic [31:0] rem_ff, rem_in;
   logic signed [31:0] meas_ff, meas_in;

   logic signed [MUL_W-1:0] op_a, op_b;
   logic signed [PROD_W-1:0] gsum, rnd;
   logic signed [NUM_W-1:0] r48, s48, n48, y48;
   logic [MUL_W-1:0] div_d, div_t, remc;
   logic signed [MUL_W:0] cdiff;

   // Operand selection for the shared multiplier.
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (st_ff)
         4'd0: begin
            op_a = MUL_W'({1'b0, cfg.bias_decay});
            op_b = MUL_W'(gm_bias_ff);
         end
         4'd1: begin
            op_a = MUL_W'({1'b0, cfg.drive_sigma});
            op_b = MUL_W'($signed(item.gm_drive));
         end
         4'd2: begin
            op_a = MUL_W'($signed(cfg.m_row[0]));
            op_b = MUL_W'($signed(item.truth[0]));
         end
         4'd3: begin
            op_a = MUL_W'($signed(cfg.m_row[1]));
            op_b = MUL_W'($signed(item.truth[1]));
         end
         4'd4: begin
            op_a = MUL_W'($signed(cfg.m_row[2]));
            op_b = MUL_W'($signed(item.truth[2]));
         end
         4'd5: begin
            op_a = MUL_W'($signed(cfg.turnon));
            op_b = {1'b0, item.interval};
         end
         4'd6: begin
            op_a = MUL_W'(gm_bias_ff);
            op_b = {1'b0, item.interval};
         end
         4'd7: begin
            op_a = MUL_W'({1'b0, cfg.white_sigma});
            op_b = MUL_W'($signed(item.noise_draw));
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // Arithmetic shared by the sequencer steps.
   always_comb begin
      prod_in = op_a * op_b;
      gsum    = gacc_ff + (prod_ff <<< 16) + (PROD_W'(1) <<< 27);
      rnd     = (uacc_ff + (PROD_W'(1) <<< (DIST_BITS - 1))) >>> DIST_BITS;
      r48     = rnd[NUM_W-1:0];
      s48     = r48 + NUM_W'(carry_ff);
      n48     = (s48 <<< 1) + NUM_W'({1'b0, cfg.quantum});
      div_d   = MUL_W'({cfg.quantum, 1'b0});
      div_t   = {rem_ff, mag_ff[NUM_W-1]};
      if (num_ff[NUM_W-1] && (rem_ff != '0)) begin
         remc = div_d - MUL_W'(rem_ff);
      end else begin
         remc = MUL_W'(rem_ff);
      end
      y48   = (num_ff - $signed(NUM_W'(remc))) >>> 1;
      cdiff = ($signed({1'b0, remc}) - $signed((MUL_W+1)'({1'b0, cfg.quantum}))) >>> 1;
   end

   // Sequencer: next state and register updates.
   always_comb begin
      state_in   = state_ff;
      st_in      = st_ff;
      cnt_in     = cnt_ff;
      gacc_in    = gacc_ff;
      uacc_in    = uacc_ff;
      gm_bias_in = gm_bias_ff;
      carry_in   = carry_ff;
      num_in     = num_ff;
      mag_in     = mag_ff;
      rem_in     = rem_ff;
      meas_in    = meas_ff;
      case (state_ff)
         LN_IDLE: begin
            if (ctl.start) begin
               state_in = LN_MUL;
               st_in    = '0;
               uacc_in  = PROD_W'($signed(item.truth_self)) <<< DIST_BITS;
            end
         end
         LN_MUL: begin
            st_in = st_ff + 4'd1;
            case (st_ff)
               4'd1: gacc_in = prod_ff <<< 12;
               4'd2: gm_bias_in = sat32(NUM_W'(gsum >>> 28));
               4'd3, 4'd4, 4'd5: uacc_in = uacc_ff + prod_ff;
               4'd6: uacc_in = uacc_ff + (prod_ff >>> 4);
               4'd7: uacc_in = uacc_ff + (prod_ff >>> 8);
               4'd8: uacc_in = uacc_ff + (prod_ff <<< 12);
               4'd9: begin
                  if (cfg.quantum == '0) begin
                     meas_in  = sat32(r48);
                     state_in = LN_DONE;
                  end else begin
                     num_in   = n48;
                     mag_in   = n48[NUM_W-1] ? NUM_W'(-n48) : NUM_W'(n48);
                     rem_in   = '0;
                     cnt_in   = '0;
                     state_in = LN_DIV;
                  end
               end
               default: ;
            endcase
         end
         LN_DIV: begin
            // One remainder bit per cycle.
            if (div_t >= div_d) begin
               rem_in = 32'(div_t - div_d);
            end else begin
               rem_in = div_t[31:0];
            end
            mag_in = mag_ff << 1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               state_in = LN_FIN;
            end
         end
         LN_FIN: begin
            meas_in  = sat32(y48);
            carry_in = cdiff[31:0];
            state_in = LN_DONE;
         end
         LN_DONE: begin
            if (ctl.ack) begin
               state_in = LN_IDLE;
            end
         end
         default: state_in = LN_IDLE;
      endcase
   end

   // Control state and per-axis model state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= LN_IDLE;
         st_ff      <= '0;
         cnt_ff     <= '0;
         gm_bias_ff <= '0;
         carry_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         st_ff      <= st_in;
         cnt_ff     <= cnt_in;
         gm_bias_ff <= gm_bias_in;
         carry_ff   <= carry_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      gacc_ff <= gacc_in;
      uacc_ff <= uacc_in;
      num_ff  <= num_in;
      mag_ff  <= mag_in;
      rem_ff  <= rem_in;
      meas_ff <= meas_in;
   end

   assign done = (state_ff == LN_DONE);
   assign meas = meas_ff;

endmodule

[rtl/imu_triad_error_model_top.sv]
// IMU triad error model: an item is taken, its three axes are worked out
// in three lanes side by side, and the merged word is offered on rsp_.
// With a nonzero quantum a word goes from acceptance to rsp_valid through
// the lane start register, ten steps through each lane's single shared
// multiplier, the bit-serial remainder unit of the quantizer, the finish
// step and the output register. With a zero quantum the remainder steps
// are skipped.
// req_stall stays high while a word is in work, so a new word is taken only
// after the last has left the lanes, later while rsp_ is stalled;
// a finished word waits in the output register while the next one is accepted.
module imu_triad_error_model_top
   import imu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [30:0] quantum_ff;
   logic [15:0] bias_decay_ff;
   logic [30:0] drive_sigma_ff;
   logic [30:0] white_sigma_ff;
   logic [47:0] scale_ff, mis1_ff, mis2_ff;
   logic [62:0] turnon_ff;

   req_type     req_ff;
   rsp_type     rsp_ff;
   logic        busy_ff, start_ff, rsp_valid_ff;

   logic [AXES-1:0][2:0][15:0] m_mat;
   lane_cfg_type  [AXES-1:0] lane_cfg;
   lane_item_type [AXES-1:0] lane_item;
   lane_ctl_type  lane_ctl;
   logic [AXES-1:0] lane_done;
   logic signed [31:0] lane_meas [AXES];
   logic accept, ack;

   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff     <= '0;
         bias_decay_ff  <= '0;
         drive_sigma_ff <= '0;
         white_sigma_ff <= '0;
         scale_ff       <= '0;
         mis1_ff        <= '0;
         mis2_ff        <= '0;
         turnon_ff      <= '0;
      end else if (csr_valid && (csr_index < 8'(NUM_REGS))) begin
         case (reg_idx_type'(csr_index[2:0]))
            REG_QUANTUM:         quantum_ff     <= csr_data[30:0];
            REG_BIAS_DECAY:      bias_decay_ff  <= csr_data[15:0];
            REG_DRIVE_SIGMA:     drive_sigma_ff <= csr_data[30:0];
            REG_WHITE_SIGMA:     white_sigma_ff <= csr_data[30:0];
            REG_SCALE_DIAG:      scale_ff       <= csr_data[47:0];
            REG_MISALIGN_FIRST:  mis1_ff        <= csr_data[47:0];
            REG_MISALIGN_SECOND: mis2_ff        <= csr_data[47:0];
            REG_TURNON_BIAS:     turnon_ff      <= csr_data[62:0];
            default: ;
         endcase
      end
   end

   // Distortion matrix, row = measured axis, column = true axis.
   always_comb begin
      m_mat[0][0] = scale_ff[15:0];
      m_mat[0][1] = mis1_ff[15:0];
      m_mat[0][2] = mis1_ff[31:16];
      m_mat[1][0] = mis1_ff[47:32];
      m_mat[1][1] = scale_ff[31:16];
      m_mat[1][2] = mis2_ff[15:0];
      m_mat[2][0] = mis2_ff[31:16];
      m_mat[2][1] = mis2_ff[47:32];
      m_mat[2][2] = scale_ff[47:32];
   end

   // Per-lane settings and item fields.
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         lane_cfg[i].quantum     = quantum_ff;
         lane_cfg[i].bias_decay  = bias_decay_ff;
         lane_cfg[i].drive_sigma = drive_sigma_ff;
         lane_cfg[i].white_sigma = white_sigma_ff;
         lane_cfg[i].m_row       = m_mat[i];
         lane_cfg[i].turnon      = turnon_ff[21*i +: 21];
         lane_item[i].truth      = {req_ff.truth_z, req_ff.truth_y, req_ff.truth_x};
         lane_item[i].interval   = req_ff.interval;
      end
      lane_item[0].truth_self = req_ff.truth_x;
      lane_item[1].truth_self = req_ff.truth_y;
      lane_item[2].truth_self = req_ff.truth_z;
      lane_item[0].gm_drive   = req_ff.gm_drive_x;
      lane_item[1].gm_drive   = req_ff.gm_drive_y;
      lane_item[2].gm_drive   = req_ff.gm_drive_z;
      lane_item[0].noise_draw = req_ff.noise_draw_x;
      lane_item[1].noise_draw = req_ff.noise_draw_y;
      lane_item[2].noise_draw = req_ff.noise_draw_z;
   end

   for (genvar g = 0; g < AXES; g++) begin : g_lane
      imu_lane u_lane (
         .clock (clock),
         .reset (reset),
         .ctl   (lane_ctl),
         .cfg   (lane_cfg[g]),
         .item  (lane_item[g]),
         .done  (lane_done[g]),
         .meas  (lane_meas[g])
      );
   end

   // Merge: all lanes done and the output register free.
   assign accept         = req_valid && !req_stall;
   assign ack            = busy_ff && (&lane_done) && (!rsp_valid_ff || !rsp_stall);
   assign lane_ctl.start = start_ff;
   assign lane_ctl.ack   = ack;
   assign req_stall      = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= accept;
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (ack) begin
            busy_ff <= 1'b0;
         end
         if (ack) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Input capture and output word.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (ack) begin
         rsp_ff.meas_x <= lane_meas[0];
         rsp_ff.meas_y <= lane_meas[1];
         rsp_ff.meas_z <= lane_meas[2];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/imu_port_checker.sv]
// Port-level checks for imu_triad_error_model_top, attached by bind.
// Depends on imu_pkg for the word types.
module imu_port_checker
   import imu_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A stalled output word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("output word changed while stalled");

   // The block takes one word at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second word accepted while busy");

   // A result never shows up the cycle right after an accept.
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // Nothing is offered right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !req_stall))
      else $error("outputs not idle after reset");

endmodule

bind imu_triad_error_model_top imu_port_checker u_imu_port_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
